// ===== rtl/plip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plip_pkg
// shared types and codes for the prefixed integer literal parser
// ----------------------------------------------------------------------------
package plip_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned STAT_W  = 2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_NAN     = 2'd0;
	localparam logic [STAT_W-1:0] ST_VALID   = 2'd1;
	localparam logic [STAT_W-1:0] ST_TOO_BIG = 2'd2;

	// characters with a meaning of their own
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
	localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
	localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h58;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
		logic              force_negative;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]         status;
		logic signed [VALUE_W-1:0] value;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/plip_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plip_in_if
// character channel: valid, ready and one character per transaction
// ----------------------------------------------------------------------------
interface plip_in_if
	import plip_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/plip_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plip_out_if
// result channel: valid, ready and one parsed literal per transaction
// ----------------------------------------------------------------------------
interface plip_out_if
	import plip_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/prefixed_integer_literal_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefixed_integer_literal_parser_core
// streaming parser for signed ascii integer literals in binary, octal,
// decimal and hex
// ----------------------------------------------------------------------------
// One character enters per transaction on chars; the transaction marked
// last_char yields exactly one transaction on result, no other character
// yields any. A character is taken every cycle while results are drained:
// each character is held in an input register, then one pass of decode
// and accumulate (a shift, or a times-ten add) updates the parse state
// and, on the last character, loads the result register. The result
// register frees itself in the same cycle its transaction completes, so
// a stalled consumer only holds back input once a second result is ready
// behind it.
// ----------------------------------------------------------------------------
module prefixed_integer_literal_parser_core
	import plip_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	plip_in_if.sink     chars,
	plip_out_if.source  result
);

	// parse phase codes
	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_ZERO  = 2'd2;
	localparam logic [1:0] PH_DIGIT = 2'd3;

	// radix codes
	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_BIN = 2'd1;
	localparam logic [1:0] RX_OCT = 2'd2;
	localparam logic [1:0] RX_HEX = 2'd3;

	// input register
	logic     valid_s1;
	in_item_t item_s1;

	// result register: raw magnitude plus a negate mark, zero unless valid
	logic               valid_s2;
	logic [STAT_W-1:0]  status_s2;
	logic [VALUE_W-1:0] mag_s2;
	logic               neg_s2;

	// parse state
	logic [1:0]         phase_q;
	logic [1:0]         radix_q;
	logic [VALUE_W-1:0] acc_q;
	logic               neg_q;
	logic               bad_q;

	// next parse state
	logic [1:0]         phase_d;
	logic [1:0]         radix_d;
	logic [VALUE_W-1:0] acc_d;
	logic               neg_d;
	logic               bad_d;

	logic               take_first;
	logic               take_digit;
	logic               digit_ok;
	logic [3:0]         digit_val;
	logic [1:0]         digit_radix;
	logic [VALUE_W-1:0] acc_tenfold;
	logic               advance;
	logic [STAT_W-1:0]  status_d;

	// stage one moves on unless it holds a last character and the result
	// register is occupied and stalled
	assign advance     = valid_s1 && (!item_s1.last_char || !valid_s2 || result.ready);
	assign chars.ready = !valid_s1 || advance;

	// a character right after the leading zero is read as octal
	assign digit_radix = (phase_q == PH_ZERO) ? RX_OCT : radix_q;

	// digit decode for the selected radix
	always_comb begin
		digit_ok  = 1'b0;
		digit_val = item_s1.char_code[3:0];
		case (digit_radix)
			RX_BIN: digit_ok = (item_s1.char_code == CH_ZERO) || (item_s1.char_code == CH_ONE);
			RX_OCT: digit_ok = item_s1.char_code inside {[CH_ZERO:CH_SEVEN]};
			RX_HEX: begin
				if (item_s1.char_code inside {[CH_ZERO:CH_NINE]}) begin
					digit_ok = 1'b1;
				end else if (item_s1.char_code inside {[CH_A:CH_F]}) begin
					digit_ok  = 1'b1;
					digit_val = 4'(item_s1.char_code - CH_A + 8'd10);
				end
			end
			default: digit_ok = item_s1.char_code inside {[CH_ZERO:CH_NINE]};
		endcase
	end

	// times ten plus the digit, as two shifts and two adds
	assign acc_tenfold = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0}
		+ VALUE_W'(digit_val);

	always_comb begin
		phase_d    = phase_q;
		radix_d    = radix_q;
		acc_d      = acc_q;
		neg_d      = neg_q;
		bad_d      = bad_q;
		take_first = 1'b0;
		take_digit = 1'b0;

		case (phase_q)
			PH_START: begin
				neg_d   = item_s1.force_negative;
				bad_d   = 1'b0;
				acc_d   = '0;
				radix_d = RX_DEC;
				if (item_s1.char_code == CH_MINUS) begin
					neg_d   = 1'b1;
					phase_d = PH_SIGN;
				end else if (item_s1.char_code == CH_PLUS) begin
					phase_d = PH_SIGN;
				end else begin
					take_first = 1'b1;
				end
			end
			PH_SIGN: take_first = 1'b1;
			PH_ZERO: begin
				// prefix letter or first octal digit
				if (item_s1.char_code == CH_B) begin
					radix_d = RX_BIN;
				end else if (item_s1.char_code == CH_X) begin
					radix_d = RX_HEX;
				end else begin
					radix_d    = RX_OCT;
					take_digit = 1'b1;
				end
				phase_d = PH_DIGIT;
			end
			default: take_digit = 1'b1;
		endcase

		// first character after the optional sign
		if (take_first) begin
			if (!(item_s1.char_code inside {[CH_ZERO:CH_NINE]})) begin
				bad_d   = 1'b1;
				phase_d = PH_DIGIT;
			end else if (item_s1.char_code == CH_ZERO) begin
				phase_d = PH_ZERO;
			end else begin
				radix_d = RX_DEC;
				acc_d   = VALUE_W'(item_s1.char_code[3:0]);
				phase_d = PH_DIGIT;
			end
		end

		// fold a digit in, sticky failure once a bad character is seen
		if (take_digit && !bad_q) begin
			if (!digit_ok) begin
				bad_d = 1'b1;
			end else begin
				case (radix_d)
					RX_BIN:  acc_d = {acc_q[VALUE_W-2:0], digit_val[0]};
					RX_OCT:  acc_d = {acc_q[VALUE_W-4:0], digit_val[2:0]};
					RX_HEX:  acc_d = {acc_q[VALUE_W-5:0], digit_val};
					default: acc_d = acc_tenfold;
				endcase
			end
		end
	end

	// status of a literal that ends with this character
	always_comb begin
		if (bad_d || phase_d == PH_SIGN) begin
			status_d = ST_NAN;
		end else if (neg_d && acc_d[VALUE_W-1]) begin
			status_d = ST_TOO_BIG;
		end else begin
			status_d = ST_VALID;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			item_s1 <= chars.data;
		end
	end

	// parse state, back to its start values after each last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			radix_q <= RX_DEC;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			bad_q   <= 1'b0;
		end else if (advance) begin
			if (item_s1.last_char) begin
				phase_q <= PH_START;
				radix_q <= RX_DEC;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				bad_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				radix_q <= radix_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				bad_q   <= bad_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && item_s1.last_char) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_char) begin
			status_s2 <= status_d;
			mag_s2    <= (status_d == ST_VALID) ? acc_d : '0;
			neg_s2    <= neg_d;
		end
	end

	// negation after the register keeps it off the accumulate path
	assign result.valid        = valid_s2;
	assign result.data.status  = status_s2;
	assign result.data.value   = neg_s2 ? (VALUE_W'(0) - mag_s2) : mag_s2;

endmodule
`default_nettype wire

// ===== test/prefixed_integer_literal_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefixed_integer_literal_parser_core_tb
// streams ascii literals into the parser, one character per transaction, and
// checks every parsed result against an in-bench literal decoder; directed
// cases first, then random well-formed and broken literals under varying
// idling on both channels and one long result stall
// ----------------------------------------------------------------------------
module prefixed_integer_literal_parser_core_tb;
	import plip_pkg::*;

	// decoder phase within one literal and the base selected by its prefix
	typedef enum logic [1:0] {LIT_START, LIT_SIGN, LIT_ZERO, LIT_DIGITS} lit_phase_t;
	typedef enum logic [1:0] {BASE_DEC, BASE_BIN, BASE_OCT, BASE_HEX} lit_base_t;

	localparam string HEX_DIGITS = "0123456789ABCDEF";
	// values around the signed and unsigned 64-bit limits
	localparam string EDGE_DECIMALS [4] = '{
		"9223372036854775807", "9223372036854775808",
		"18446744073709551615", "18446744073709551616"
	};

	logic clk;
	logic arst_n;

	plip_in_if  chars_if ();
	plip_out_if result_if ();

	prefixed_integer_literal_parser_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	// literal decoder state, kept in step with accepted characters
	lit_phase_t  lit_phase = LIT_START;
	lit_base_t   lit_base  = BASE_DEC;
	logic [63:0] lit_acc   = '0;
	logic        lit_neg   = 1'b0;
	logic        lit_bad   = 1'b0;

	// parsed results still owed by the block, oldest first
	out_item_t pending_results [$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int stall_left   = 0;
	int fail_count   = 0;
	int chars_sent   = 0;
	int n_valid      = 0;
	int n_nan        = 0;
	int n_too_big    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous upper bound on the whole run
	initial begin
		#(3_000_000);
		$display("timeout: parser stopped making progress");
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------------
	// literal decoder
	// ------------------------------------------------------------------------

	// checks one digit against the selected base and folds it in
	function automatic void fold_digit(logic [7:0] c);
		logic [3:0] nib;
		if (lit_bad)
			return;
		case (lit_base)
			BASE_BIN: begin
				if (c == CH_ZERO || c == CH_ONE)
					lit_acc = {lit_acc[62:0], c[0]};
				else
					lit_bad = 1'b1;
			end
			BASE_OCT: begin
				if (c >= CH_ZERO && c <= CH_SEVEN)
					lit_acc = {lit_acc[60:0], c[2:0]};
				else
					lit_bad = 1'b1;
			end
			BASE_HEX: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					nib = c[3:0];
					lit_acc = {lit_acc[59:0], nib};
				end else if (c >= CH_A && c <= CH_F) begin
					nib = 4'(c - CH_A + 8'd10);
					lit_acc = {lit_acc[59:0], nib};
				end else begin
					lit_bad = 1'b1;
				end
			end
			default: begin
				if (c >= CH_ZERO && c <= CH_NINE)
					lit_acc = lit_acc * 64'd10 + 64'(c - CH_ZERO);
				else
					lit_bad = 1'b1;
			end
		endcase
	endfunction

	// first character after an optional sign
	function automatic void lead_digit(logic [7:0] c);
		if (c < CH_ZERO || c > CH_NINE) begin
			lit_bad   = 1'b1;
			lit_phase = LIT_DIGITS;
		end else if (c == CH_ZERO) begin
			lit_phase = LIT_ZERO;
		end else begin
			lit_base  = BASE_DEC;
			lit_acc   = 64'(c - CH_ZERO);
			lit_phase = LIT_DIGITS;
		end
	endfunction

	// advances the decoder by one accepted character; a last character
	// queues the parsed result and rearms for the next literal
	function automatic void decode_char(in_item_t it);
		out_item_t res;
		case (lit_phase)
			LIT_START: begin
				lit_neg  = it.force_negative;
				lit_bad  = 1'b0;
				lit_acc  = '0;
				lit_base = BASE_DEC;
				if (it.char_code == CH_MINUS) begin
					lit_neg   = 1'b1;
					lit_phase = LIT_SIGN;
				end else if (it.char_code == CH_PLUS) begin
					lit_phase = LIT_SIGN;
				end else begin
					lead_digit(it.char_code);
				end
			end
			LIT_SIGN: lead_digit(it.char_code);
			LIT_ZERO: begin
				if (it.char_code == CH_B) begin
					lit_base = BASE_BIN;
				end else if (it.char_code == CH_X) begin
					lit_base = BASE_HEX;
				end else begin
					lit_base = BASE_OCT;
					fold_digit(it.char_code);
				end
				lit_phase = LIT_DIGITS;
			end
			default: fold_digit(it.char_code);
		endcase
		if (!it.last_char)
			return;
		if (lit_bad || lit_phase == LIT_SIGN) begin
			res.status = ST_NAN;
			res.value  = '0;
		end else if (lit_neg && lit_acc[63]) begin
			// magnitude with bit 63 set, reported as too big for a negative value
			res.status = ST_TOO_BIG;
			res.value  = '0;
		end else if (lit_neg) begin
			res.status = ST_VALID;
			res.value  = 64'd0 - lit_acc;
		end else begin
			res.status = ST_VALID;
			res.value  = lit_acc;
		end
		pending_results.push_back(res);
		lit_phase = LIT_START;
		lit_base  = BASE_DEC;
		lit_acc   = '0;
		lit_neg   = 1'b0;
		lit_bad   = 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// result side: ready pattern with an optional long hold-off, and checking
	// ------------------------------------------------------------------------
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_result
		out_item_t want;
		if (result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no literal pending: status %0d value %0d",
					result_if.data.status, result_if.data.value);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_if.data.status !== want.status) begin
					$error("status: expected %0d, actual %0d",
						want.status, result_if.data.status);
					fail_count++;
				end
				if (result_if.data.value !== want.value) begin
					$error("value: expected %0d, actual %0d",
						want.value, result_if.data.value);
					fail_count++;
				end
				case (want.status)
					ST_VALID:   n_valid++;
					ST_TOO_BIG: n_too_big++;
					default:    n_nan++;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// character side
	// ------------------------------------------------------------------------

	// offers one character, with random idle cycles in front of it, and
	// feeds it to the decoder once the transaction completes
	task automatic send_char(input logic [7:0] c, input logic last, input logic force_neg);
		in_item_t it;
		it.char_code      = c;
		it.last_char      = last;
		it.force_negative = force_neg;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.data  <= it;
		do @(posedge clk); while (!chars_if.ready);
		decode_char(it);
		chars_sent++;
	endtask

	// force_negative only counts on the first character, so it is random on
	// the rest to show that it is ignored there
	task automatic send_literal(input logic [7:0] text [$], input logic force_neg);
		foreach (text[i])
			send_char(text[i], i == text.size() - 1,
				(i == 0) ? force_neg : 1'($urandom_range(0, 1)));
	endtask

	task automatic send_text(input string s, input logic force_neg);
		logic [7:0] text [$];
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
		send_literal(text, force_neg);
	endtask

	// drops valid so the last character is not taken twice
	task automatic release_input();
		@(negedge clk);
		chars_if.valid <= 1'b0;
	endtask

	// only called with valid low, so the posedge cannot take a character
	task automatic set_idling(input int src_pct, input int snk_pct);
		@(posedge clk);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
	endtask

	task automatic hold_results(input int n);
		@(posedge clk);
		stall_left = n;
	endtask

	// random literal: mostly well-formed in every base, with some sign-only,
	// corrupted and pure noise literals
	task automatic gen_literal(output logic [7:0] text [$], output logic force_neg);
		int    kind;
		int    len;
		int    pos;
		string s;
		text      = {};
		force_neg = ($urandom_range(0, 3) == 0);
		kind      = $urandom_range(0, 99);
		if (kind >= 92) begin
			// noise: any byte values, covers every char_code bit
			repeat ($urandom_range(1, 6))
				text.push_back(8'($urandom_range(0, 255)));
			return;
		end
		case ($urandom_range(0, 3))
			0:       text.push_back(CH_MINUS);
			1:       text.push_back(CH_PLUS);
			default: ;
		endcase
		if (kind < 20) begin
			// decimal, long enough at times to wrap
			text.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
			repeat ($urandom_range(0, 20))
				text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end else if (kind < 38) begin
			// hex; a full 16 digits often has the top bit set
			text.push_back(CH_ZERO);
			text.push_back(CH_X);
			len = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(0, 12);
			repeat (len)
				text.push_back(HEX_DIGITS[$urandom_range(0, 15)]);
		end else if (kind < 52) begin
			text.push_back(CH_ZERO);
			text.push_back(CH_B);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 16);
			repeat (len)
				text.push_back(8'(CH_ZERO + $urandom_range(0, 1)));
		end else if (kind < 66) begin
			// octal; no digits after the zero gives a lone zero
			text.push_back(CH_ZERO);
			repeat ($urandom_range(0, 22))
				text.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
		end else if (kind < 74) begin
			s = EDGE_DECIMALS[$urandom_range(0, 3)];
			for (int i = 0; i < s.len(); i++)
				text.push_back(s[i]);
		end else if (kind < 77) begin
			// sign with nothing after it
			if (text.size() == 0)
				text.push_back(CH_MINUS);
		end else begin
			// prefixed literal with one character spoilt
			text.push_back(CH_ZERO);
			text.push_back($urandom_range(0, 1) ? CH_X : CH_B);
			repeat ($urandom_range(1, 8))
				text.push_back(HEX_DIGITS[$urandom_range(0, 15)]);
			pos = $urandom_range(0, text.size() - 1);
			text[pos] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(8'h61, 8'h7A));
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	task automatic test_signs_and_zero();
		send_text("0", 1'b0);
		send_text("-0", 1'b0);
		send_text("+7", 1'b0);
		send_text("-", 1'b0);
		send_text("+", 1'b1);
		send_text("5", 1'b1);     // negated by the force flag alone
		send_text("A", 1'b0);     // no digit up front
		send_text("-Z", 1'b0);
		release_input();
	endtask

	task automatic test_prefixes();
		send_text("0B", 1'b0);    // bare prefixes give zero
		send_text("0X", 1'b1);
		send_text("-0B101", 1'b0);
		send_text("0777", 1'b0);
		send_text("0XAF09", 1'b0);
		send_text("0b1", 1'b0);   // lowercase falls into octal and fails
		release_input();
	endtask

	task automatic test_bad_digits();
		send_text("0B102", 1'b0);
		send_text("08", 1'b0);
		send_text("0XFG", 1'b0);
		send_text("12A", 1'b0);
		release_input();
	endtask

	task automatic test_extremes();
		logic [7:0] text [$];
		send_text("0XFFFFFFFFFFFFFFFF", 1'b0);
		send_text("-0X8000000000000000", 1'b0);
		send_text("0X8000000000000000", 1'b1);
		send_text("-9223372036854775807", 1'b0);
		send_text("18446744073709551616", 1'b0);  // wraps round to zero
		text.push_back(8'h00);
		send_literal(text, 1'b0);
		text[0] = 8'hFF;
		send_literal(text, 1'b1);
		release_input();
	endtask

	task automatic test_random(input int n_chars);
		logic [7:0] text [$];
		logic       force_neg;
		int         start;
		start = chars_sent;
		while (chars_sent - start < n_chars) begin
			gen_literal(text, force_neg);
			send_literal(text, force_neg);
		end
		release_input();
	endtask

	// results held off for a long stretch while characters keep coming, so
	// the result register and the one behind it fill and input backs up
	task automatic test_backpressure();
		logic [7:0] text [$];
		logic       force_neg;
		hold_results(400);
		repeat (15) begin
			gen_literal(text, force_neg);
			send_literal(text, force_neg);
		end
		release_input();
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		int waited;
		chars_if.valid = 1'b0;
		chars_if.data  = '0;
		arst_n         = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_idling(8, 62);
		test_signs_and_zero();
		test_prefixes();
		test_bad_digits();
		test_extremes();
		test_random(200);

		set_idling(62, 8);
		test_random(200);

		set_idling(0, 0);
		test_backpressure();
		test_random(200);

		// drain, then keep watching for stray results
		waited = 0;
		while (pending_results.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end

		$display("%0d characters sent; results checked: %0d valid, %0d not a number, %0d too big",
			chars_sent, n_valid, n_nan, n_too_big);
		$display("all bases, signs, bad digits and wrap, under three idling mixes and a long stall");
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/plip_pkg.sv
rtl/plip_in_if.sv
rtl/plip_out_if.sv
rtl/prefixed_integer_literal_parser_core.sv
test/prefixed_integer_literal_parser_core_tb.sv
